### hw/rtl/bounded_sequence_list_assert.svh
// Assertion macros used by the bounded sequence list top level.
`ifndef BOUNDED_SEQUENCE_LIST_ASSERT_SVH
`define BOUNDED_SEQUENCE_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bsl_pkg.sv
// Types, codes and sizes for the bounded sequence list.
package bsl_pkg;

    localparam int CAPACITY    = 256;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int POS_W       = 9;
    localparam int COUNT_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int TAIL_GRP    = 16;
    localparam int TAIL_NGRP   = (CAPACITY + TAIL_GRP - 1) / TAIL_GRP;

    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_data EMPTY_MARK = 32'h7FFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        t_data     value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAIL_GROUP,
        S_TAIL_FINAL
    } t_state;

endpackage

### hw/rtl/bsl_cell.sv
// One storage cell of the list row: hold, load, or take a neighbor's word.
module bsl_cell
    import bsl_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_data     i_left,
    input  t_data     i_right,
    output t_data     o_value
);

    t_data r_value;
    t_data n_value;

    always_comb begin
        case (i_ctl.cmd)
            CELL_LOAD:       n_value = i_ctl.value;
            CELL_FROM_LEFT:  n_value = i_left;
            CELL_FROM_RIGHT: n_value = i_right;
            default:         n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### hw/rtl/bsl_tail_sel.sv
// Two-stage select of the last occupied cell: registered per-group OR, then a combinational OR of the groups.
module bsl_tail_sel
    import bsl_pkg::*;
(
    input  logic   i_clk,
    input  t_data  i_cells [CAPACITY],
    input  t_count i_count,
    output t_data  o_tail
);

    t_count w_last;
    t_data  w_masked [TAIL_NGRP*TAIL_GRP];
    t_data  r_grp    [TAIL_NGRP];
    t_data  n_grp    [TAIL_NGRP];

    assign w_last = i_count - t_count'(1);

    for (genvar k = 0; k < TAIL_NGRP*TAIL_GRP; k++) begin : g_mask
        if (k < CAPACITY) begin : g_real
            assign w_masked[k] = i_cells[k] & {DATA_W{w_last == COUNT_W'(k)}};
        end else begin : g_pad
            assign w_masked[k] = '0;
        end
    end

    for (genvar g = 0; g < TAIL_NGRP; g++) begin : g_group
        always_comb begin
            n_grp[g] = '0;
            for (int j = 0; j < TAIL_GRP; j++) begin
                n_grp[g] = n_grp[g] | w_masked[g*TAIL_GRP + j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp[g] <= n_grp[g];
        end
    end

    always_comb begin
        o_tail = '0;
        for (int g = 0; g < TAIL_NGRP; g++) begin
            o_tail = o_tail | r_grp[g];
        end
    end

endmodule

### hw/rtl/bounded_sequence_list.sv
// Top level of the bounded sequence list: row of cells, op decode, result register.
//
//   channel | dir | fields (lsb first)
//   s_axis  | in  | opcode[2:0] value[34:3] position[43:35]
//   m_axis  | out | removed_value[31:0] status[33:32] count[42:34]
//
// Every word but a pop back of a nonempty list: result valid the cycle after accept;
// at that accept edge a pop front shifts the whole row closed, and a push or insert loads
// its index and shifts the cells above it open. Pop back of a nonempty list: the result
// is loaded in S_TAIL_FINAL after S_TAIL_GROUP; input is held off through both tail states.
// Reset clears the count, the state and the result valid; cells stay undefined until written.
// One result register: a new word is taken only while it is empty or drained.
`include "bounded_sequence_list_assert.svh"

module bounded_sequence_list
    import bsl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // opcode, value, position
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // removed_value, status, count
);

    t_state  r_state;
    t_state  n_state;
    t_count  r_count;
    logic    r_out_valid;
    t_data   r_res_removed;
    t_status r_res_status;
    t_count  r_res_count;

    logic    w_in_rdy;
    logic    w_in_acc;
    logic    w_full;
    logic    w_empty;
    logic    w_pos_ok;
    logic    w_ins_go;
    logic    w_popf_go;
    logic    w_popb_go;
    t_count  w_ins_idx;
    t_data   w_removed;
    t_status w_status;
    t_count  w_new_count;
    logic    w_res_load;
    logic    w_tail_done;
    t_data   w_tail;

    logic [OP_W-1:0]  w_op;
    t_data            w_value;
    logic [POS_W-1:0] w_pos;

    t_data     w_cells [CAPACITY];
    t_cell_ctl w_ctl   [CAPACITY];

    assign w_op    = s_axis_tdata[OP_W-1:0];
    assign w_value = s_axis_tdata[OP_W +: DATA_W];
    assign w_pos   = s_axis_tdata[OP_W+DATA_W +: POS_W];

    assign w_in_rdy = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_in_acc = s_axis_tvalid && w_in_rdy;
    assign w_full   = r_count == t_count'(CAPACITY);
    assign w_empty  = r_count == '0;
    assign w_pos_ok = !w_pos[POS_W-1] && (t_count'(w_pos) <= r_count);

    // Operation decode
    always_comb begin
        w_ins_go    = 1'b0;
        w_popf_go   = 1'b0;
        w_popb_go   = 1'b0;
        w_ins_idx   = '0;
        w_removed   = '0;
        w_status    = ST_OK;
        w_new_count = r_count;
        unique case (w_op)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_go    = 1'b1;
                    w_new_count = r_count + t_count'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_go    = 1'b1;
                    w_ins_idx   = r_count;
                    w_new_count = r_count + t_count'(1);
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status  = ST_EMPTY;
                    w_removed = EMPTY_MARK;
                end else begin
                    w_popf_go   = 1'b1;
                    w_removed   = w_cells[0];
                    w_new_count = r_count - t_count'(1);
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    w_status  = ST_EMPTY;
                    w_removed = EMPTY_MARK;
                end else begin
                    w_popb_go = 1'b1;
                end
            end
            OP_INSERT: begin
                if (!w_pos_ok) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_go    = 1'b1;
                    w_ins_idx   = t_count'(w_pos);
                    w_new_count = r_count + t_count'(1);
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // State machine: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_popb_go) begin
                    n_state = S_TAIL_GROUP;
                end
            end
            S_TAIL_GROUP: n_state = S_TAIL_FINAL;
            S_TAIL_FINAL: n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // State machine: outputs
    always_comb begin
        w_res_load  = 1'b0;
        w_tail_done = 1'b0;
        unique case (r_state)
            S_IDLE:       w_res_load  = w_in_acc && !w_popb_go;
            S_TAIL_GROUP: w_res_load  = 1'b0;
            S_TAIL_FINAL: w_tail_done = 1'b1;
            default:      w_res_load  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_res_load) begin
                r_count     <= w_new_count;
                r_out_valid <= 1'b1;
            end else if (w_tail_done) begin
                r_count     <= r_count - t_count'(1);
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_res_removed <= w_removed;
            r_res_status  <= w_status;
            r_res_count   <= w_new_count;
        end else if (w_tail_done) begin
            r_res_removed <= w_tail;
            r_res_status  <= ST_OK;
            r_res_count   <= r_count - t_count'(1);
        end
    end

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_data w_left;
        t_data w_right;

        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cells[i-1];
        end

        if (i == CAPACITY-1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cells[i+1];
        end

        always_comb begin
            w_ctl[i].value = w_value;
            w_ctl[i].cmd   = CELL_HOLD;
            if (w_in_acc && w_popf_go) begin
                w_ctl[i].cmd = CELL_FROM_RIGHT;
            end else if (w_in_acc && w_ins_go) begin
                if (COUNT_W'(i) == w_ins_idx) begin
                    w_ctl[i].cmd = CELL_LOAD;
                end else if (COUNT_W'(i) > w_ins_idx) begin
                    w_ctl[i].cmd = CELL_FROM_LEFT;
                end
            end
        end

        bsl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cells[i])
        );
    end

    bsl_tail_sel u_tail_sel (
        .i_clk   (i_clk),
        .i_cells (w_cells),
        .i_count (r_count),
        .o_tail  (w_tail)
    );

    assign s_axis_tready = w_in_rdy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-DATA_W-STATUS_W-COUNT_W){1'b0}},
                            r_res_count, r_res_status, r_res_removed};

    `BSL_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= t_count'(CAPACITY), "count above capacity")
    `BSL_ASSERT_NOW(a_busy_no_accept, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready, "accept during tail select")
    `BSL_ASSERT_NEXT(a_tail_seq, i_clk, i_rst_n, r_state == S_TAIL_GROUP, r_state == S_TAIL_FINAL, "tail select out of order")
    `BSL_ASSERT_NOW(a_empty_mark, i_clk, i_rst_n, r_out_valid && r_res_status == ST_EMPTY, r_res_removed == EMPTY_MARK, "empty pop without mark")
    `BSL_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1, r_count == $past(r_count) || r_count == $past(r_count) + t_count'(1) || r_count == $past(r_count) - t_count'(1), "count moved by more than one")

endmodule

### dv/bounded_sequence_list_tb.sv
// Self-checking testbench for the bounded sequence list: directed, fill, backpressure and random ops.
module bounded_sequence_list_tb
    import bsl_pkg::*;
();

    localparam int    OP_CODES        = 8;
    localparam int    WATCHDOG_LIMIT  = 5000;
    localparam int    DRAIN_CYCLES    = 8;
    localparam int    MAX_REPORTS     = 10;
    localparam int    HOLD_OFF_CYCLES = 300;
    localparam t_data VALUE_MIN       = 32'h8000_0000;
    localparam t_data VALUE_MAX       = 32'h7FFF_FFFF;

    typedef struct {
        t_data   removed;
        t_status status;
        t_count  count;
    } t_outcome;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // opcode, value, position
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // removed_value, status, count

    t_data    list_model[$];
    t_outcome pending_results[$];
    int       src_idle_pct  = 38;
    int       sink_idle_pct = 52;
    int       sink_hold     = 0;
    int       error_count   = 0;
    int       stall_cycles  = 0;
    int       grow_bias     = 50;

    bounded_sequence_list i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_outcome predict_result(input logic [OP_W-1:0] op, input t_data value,
                                                input logic [POS_W-1:0] pos);
        t_outcome res;
        int       n;
        n = list_model.size();
        res.removed = '0;
        res.status  = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (n >= CAPACITY) res.status = ST_FULL;
                else list_model.push_front(value);
            end
            OP_PUSH_BACK: begin
                if (n >= CAPACITY) res.status = ST_FULL;
                else list_model.push_back(value);
            end
            OP_POP_FRONT: begin
                if (n == 0) begin
                    res.status  = ST_EMPTY;
                    res.removed = EMPTY_MARK;
                end else begin
                    res.removed = list_model.pop_front();
                end
            end
            OP_POP_BACK: begin
                if (n == 0) begin
                    res.status  = ST_EMPTY;
                    res.removed = EMPTY_MARK;
                end else begin
                    res.removed = list_model.pop_back();
                end
            end
            OP_INSERT: begin
                if (pos[POS_W-1] || pos > n) res.status = ST_RANGE;
                else if (n >= CAPACITY) res.status = ST_FULL;
                else list_model.insert(int'(pos), value);
            end
            default: ;
        endcase
        res.count = t_count'(list_model.size());
        return res;
    endfunction

    function automatic t_data pick_value();
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(3))
                0: return VALUE_MIN;
                1: return VALUE_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return t_data'($urandom);
    endfunction

    // Offer one word, idle at random first, and record its outcome on accept.
    task automatic send_op(input logic [OP_W-1:0] op, input t_data value,
                           input logic [POS_W-1:0] pos);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - OP_W - DATA_W - POS_W){1'b0}}, pos, value, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_result(op, value, pos));
    endtask

    task automatic send_grow_op();
        case ($urandom_range(2))
            0: send_op(OP_PUSH_FRONT, pick_value(), POS_W'($urandom));
            1: send_op(OP_PUSH_BACK, pick_value(), POS_W'($urandom));
            default: send_op(OP_INSERT, pick_value(),
                             POS_W'($urandom_range(list_model.size(), 0)));
        endcase
    endtask

    task automatic send_shrink_op();
        if ($urandom_range(1)) send_op(OP_POP_FRONT, pick_value(), POS_W'($urandom));
        else send_op(OP_POP_BACK, pick_value(), POS_W'($urandom));
    endtask

    task automatic send_random_op();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            send_op(OP_W'($urandom_range(OP_CODES - 1, int'(OP_INSERT) + 1)), pick_value(),
                    POS_W'($urandom));
        end else if (r < 9) begin
            send_op(OP_INSERT, pick_value(), POS_W'($urandom));
        end else if ($urandom_range(99) < grow_bias) begin
            send_grow_op();
        end else begin
            send_shrink_op();
        end
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        t_outcome want;
        t_data    got_removed;
        logic [STATUS_W-1:0] got_status;
        t_count   got_count;
        got_removed = word[DATA_W-1:0];
        got_status  = word[DATA_W +: STATUS_W];
        got_count   = word[DATA_W + STATUS_W +: COUNT_W];
        if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("unexpected result word: removed=%h status=%0d count=%0d",
                         got_removed, got_status, got_count);
        end else begin
            want = pending_results.pop_front();
            if (got_removed !== want.removed || got_status !== want.status
                    || got_count !== want.count) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result mismatch: expected removed=%h status=%0d count=%0d, %s",
                             want.removed, want.status, want.count,
                             $sformatf("got removed=%h status=%0d count=%0d",
                                       got_removed, got_status, got_count));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready) check_result(m_axis_tdata);
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1)
                || (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_sequence_list test failed");
            $finish;
        end
    end

    task automatic test_directed();
        int op;
        send_op(OP_POP_FRONT, VALUE_MAX, '0);
        send_op(OP_POP_BACK, VALUE_MIN, '1);
        send_op(OP_INSERT, VALUE_MIN, '0);
        send_op(OP_PUSH_BACK, VALUE_MAX, '0);
        send_op(OP_PUSH_FRONT, '0, '1);
        send_op(OP_PUSH_BACK, '1, '0);
        send_op(OP_INSERT, 32'h5555_5555, POS_W'(list_model.size()));
        send_op(OP_INSERT, 32'hAAAA_AAAA, POS_W'(2));
        send_op(OP_INSERT, 32'h0F0F_0F0F, POS_W'(list_model.size() + 1));
        send_op(OP_INSERT, 32'hF0F0_F0F0, POS_W'(255));
        send_op(OP_INSERT, 32'h1357_9BDF, POS_W'(-1));
        send_op(OP_INSERT, 32'h2468_ACE0, POS_W'(-256));
        for (op = int'(OP_INSERT) + 1; op < OP_CODES; op++)
            send_op(OP_W'(op), 32'hDEAD_BEEF, POS_W'(op));
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_POP_BACK, '1, '1);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_FRONT, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_POP_BACK, '0, '0);
        send_op(OP_PUSH_FRONT, 32'h1234_5678, '0);
        send_op(OP_POP_BACK, '0, '0);
    endtask

    task automatic test_fill_and_drain();
        while (list_model.size() < CAPACITY) send_grow_op();
        send_op(OP_PUSH_FRONT, pick_value(), '0);
        send_op(OP_PUSH_BACK, pick_value(), '0);
        send_op(OP_INSERT, pick_value(), POS_W'(10));
        send_op(OP_INSERT, pick_value(), POS_W'(255));
        send_op(OP_INSERT, pick_value(), POS_W'(-5));
        while (list_model.size() > 0) send_shrink_op();
        send_op(OP_POP_BACK, pick_value(), '0);
    endtask

    task automatic test_backpressure();
        int i;
        for (i = 0; i < 8; i++) send_grow_op();
        sink_hold = HOLD_OFF_CYCLES;
        for (i = 0; i < 40; i++) send_random_op();
    endtask

    task automatic test_random_mix(input int items, input int src_pct, input int sink_pct);
        int i;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (i = 0; i < items; i++) begin
            // wander the fill level so both full and empty are reached
            if (i % 64 == 0) grow_bias = $urandom_range(85, 15);
            send_random_op();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_drain();
        test_backpressure();
        test_random_mix(420, 38, 52);
        test_random_mix(420, 52, 38);
        test_random_mix(420, 0, 0);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("bounded_sequence_list test passed");
        end else begin
            $display("bounded_sequence_list test failed");
        end
        $finish;
    end

endmodule
